// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk outside reset.
`define CCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge of clk outside reset.
`define CCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Types and constants of the color cube slice pixel generator.
// ----------------------------------------------------------------------------
package ccs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_DIM   = 4096;
  localparam int FX_W      = FRAC_BITS + 1;          // fraction incl. the value one
  localparam logic [FX_W-1:0] ONE_FX = FX_W'(1) << FRAC_BITS;

  localparam int DIM_W  = 13;                        // image size register
  localparam int COORD_W = 12;                       // pixel coordinate
  localparam int DEN_W  = 12;                        // clamped size minus one
  localparam int QUO_W  = 25;                        // widest ramp quotient
  localparam int NUM_W  = DEN_W + QUO_W;             // ramp numerator
  localparam int HUE_W  = QUO_W;                     // hue, degrees with fraction
  localparam int H60_W  = 19;                        // hue / 60
  localparam int OFF_W  = 26;

  // Divider is QUO_W stages, then select, multiply, multiply, output
  localparam int PIPE_LEN = QUO_W + 4;

  localparam logic [26:0] RECIP_60  = 27'd71582789;  // ceil(2^32 / 60)
  localparam logic [25:0] RECIP_100 = 26'd42949673;  // ceil(2^32 / 100)

  typedef enum logic [2:0] {
    MODE_FIX_R = 3'd0,
    MODE_FIX_G = 3'd1,
    MODE_FIX_B = 3'd2,
    MODE_FIX_H = 3'd3,
    MODE_FIX_S = 3'd4,
    MODE_FIX_V = 3'd5
  } slice_mode_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_SLIDER = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL  = 3'd0,
    SEC_YEL_GRN  = 3'd1,
    SEC_GRN_CYN  = 3'd2,
    SEC_CYN_BLU  = 3'd3,
    SEC_BLU_MAG  = 3'd4,
    SEC_MAG_RED  = 3'd5
  } sector_t;

endpackage

// File: design/ccs_div.sv
// ----------------------------------------------------------------------------
// ccs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module ccs_div import ccs_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // working word: {partial remainder, numerator bits left / quotient bits}
  logic [NUM_W-1:0] w_r [QUO_W];

  function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
                                                input logic [DEN_W-1:0] d);
    logic [DEN_W:0]   cand;
    logic [DEN_W-1:0] rem;
    logic             q;
    cand = w[NUM_W-1 -: DEN_W+1];
    if (cand >= {1'b0, d}) begin
      rem = DEN_W'(cand - {1'b0, d});
      q   = 1'b1;
    end else begin
      rem = cand[DEN_W-1:0];
      q   = 1'b0;
    end
    return {rem, w[QUO_W-2:0], q};
  endfunction

  // numerator top bits are below den since quotient fits QUO_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0] <= div_step(num, den);
    end
  end

  for (genvar i = 1; i < QUO_W; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        w_r[i] <= div_step(w_r[i-1], den);
      end
    end
  end

  assign quo = w_r[QUO_W-1][QUO_W-1:0];

endmodule

// File: design/color_cube_slice_pixel_gen.sv
// ----------------------------------------------------------------------------
// color_cube_slice_pixel_gen
// Colour of one pixel of a planar RGB or HSV cube slice, plus its byte offset.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while no result is held by out_stall;
//   the 25-stage ramp dividers and the four colour stages behind them all advance together.
// A stalled output freezes the whole pipeline and raises in_stall.
// Reset (rst_n, synchronous): pipeline empty, slice_mode 0, slider 0,
//   image 600 x 600.
`include "assert_macros.svh"

module color_cube_slice_pixel_gen import ccs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [COORD_W-1:0] in_pixel_x,
  input  logic [COORD_W-1:0] in_pixel_y,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_red_value,
  output logic [7:0]         out_green_value,
  output logic [7:0]         out_blue_value,
  output logic [OFF_W-1:0]   out_pixel_offset,
  // configuration port
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]       mode_r;
  logic [8:0]       slider_r;
  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 3'(MODE_FIX_R);
      slider_r <= '0;
      width_r  <= DIM_W'(600);
      height_r <= DIM_W'(600);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:   mode_r   <= cfg_pwdata[2:0];
        REG_SLIDER: slider_r <= cfg_pwdata[8:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:   cfg_prdata = 32'(mode_r);
      REG_SLIDER: cfg_prdata = 32'(slider_r);
      REG_WIDTH:  cfg_prdata = 32'(width_r);
      REG_HEIGHT: cfg_prdata = 32'(height_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Values derived from the registers. The ramp divisors are needed at pipe
  // entry, so they take a size write directly and are valid with the size
  // registers. The rest lag, harmless as used deep in the pipe; the user must
  // change configuration only while idle, which the block does not enforce.
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] width_src, height_src;
  logic [DEN_W-1:0] wd_r, wd_nxt;         // clamped width - 1
  logic [DEN_W-1:0] hd_r, hd_nxt;         // clamped height - 1
  logic [7:0]       rgb_fix_r, rgb_fix_nxt;
  logic [8:0]       hue_fix_r, hue_fix_nxt;
  logic [FX_W-1:0]  pct_fx_r, pct_fx_nxt;
  logic [6:0]       pct;
  logic [48:0]      pct_prod;

  always_comb begin
    width_src  = (cfg_wr && cfg_idx == REG_WIDTH)  ? cfg_pwdata[DIM_W-1:0] : width_r;
    height_src = (cfg_wr && cfg_idx == REG_HEIGHT) ? cfg_pwdata[DIM_W-1:0] : height_r;
    if (width_src < DIM_W'(2))            wd_nxt = DEN_W'(1);
    else if (width_src > DIM_W'(MAX_DIM)) wd_nxt = DEN_W'(MAX_DIM - 1);
    else                                  wd_nxt = DEN_W'(width_src - DIM_W'(1));
    if (height_src < DIM_W'(2))            hd_nxt = DEN_W'(1);
    else if (height_src > DIM_W'(MAX_DIM)) hd_nxt = DEN_W'(MAX_DIM - 1);
    else                                   hd_nxt = DEN_W'(height_src - DIM_W'(1));
    rgb_fix_nxt = (slider_r > 9'd255) ? 8'd255 : slider_r[7:0];
    hue_fix_nxt = (slider_r > 9'd360) ? 9'd360 : slider_r;
    pct         = (slider_r > 9'd100) ? 7'd100 : slider_r[6:0];
    // percent / 100 by reciprocal, exact for 0..100
    pct_prod    = 49'({pct, FRAC_BITS'(0)}) * 49'(RECIP_100);
    pct_fx_nxt  = pct_prod[32 +: FX_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wd_r      <= DEN_W'(599);
      hd_r      <= DEN_W'(599);
      rgb_fix_r <= '0;
      hue_fix_r <= '0;
      pct_fx_r  <= '0;
    end else begin
      wd_r      <= wd_nxt;
      hd_r      <= hd_nxt;
      rgb_fix_r <= rgb_fix_nxt;
      hue_fix_r <= hue_fix_nxt;
      pct_fx_r  <= pct_fx_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: everything moves unless the result is held
  // --------------------------------------------------------------------------
  logic                adv;
  logic [PIPE_LEN-1:0] vld_r;

  assign adv       = !(vld_r[PIPE_LEN-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[PIPE_LEN-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Ramp dividers. Coordinates past the edge clamp to size-1, which gives
  // exactly the saturated ramp value.
  // --------------------------------------------------------------------------
  logic [COORD_W-1:0] xc, yc;
  logic [NUM_W-1:0]   num_rx, num_fx, num_hx, num_ry, num_fy;
  logic [QUO_W-1:0]   quo_rx, quo_fx, quo_hx, quo_ry, quo_fy;

  assign xc     = (in_pixel_x > wd_r) ? wd_r : in_pixel_x;
  assign yc     = (in_pixel_y > hd_r) ? hd_r : in_pixel_y;
  assign num_rx = NUM_W'(xc) * NUM_W'(255);
  assign num_fx = NUM_W'(xc) << FRAC_BITS;
  assign num_hx = (NUM_W'(xc) * NUM_W'(360)) << FRAC_BITS;
  assign num_ry = NUM_W'(yc) * NUM_W'(255);
  assign num_fy = NUM_W'(yc) << FRAC_BITS;

  ccs_div u_div_rx (.clk(clk), .en(adv), .num(num_rx), .den(wd_r), .quo(quo_rx));
  ccs_div u_div_fx (.clk(clk), .en(adv), .num(num_fx), .den(wd_r), .quo(quo_fx));
  ccs_div u_div_hx (.clk(clk), .en(adv), .num(num_hx), .den(wd_r), .quo(quo_hx));
  ccs_div u_div_ry (.clk(clk), .en(adv), .num(num_ry), .den(hd_r), .quo(quo_ry));
  ccs_div u_div_fy (.clk(clk), .en(adv), .num(num_fy), .den(hd_r), .quo(quo_fy));

  // --------------------------------------------------------------------------
  // Pixel offset: multiply, add, then a delay line matching the colour path.
  // Uses the raw width register; wraps at 26 bits.
  // --------------------------------------------------------------------------
  logic [DIM_W+COORD_W-1:0] offp_r;
  logic [COORD_W-1:0]       offx_r;
  logic [OFF_W-1:0]         off_r [1:PIPE_LEN-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      offp_r   <= (DIM_W+COORD_W)'(width_r) * (DIM_W+COORD_W)'(in_pixel_y);
      offx_r   <= in_pixel_x;
      off_r[1] <= OFF_W'({offp_r, 2'b00}) + OFF_W'({offx_r, 2'b00});
    end
  end

  for (genvar i = 2; i < PIPE_LEN; i++) begin : g_off
    always_ff @(posedge clk) begin
      if (adv) off_r[i] <= off_r[i-1];
    end
  end

  assign out_pixel_offset = off_r[PIPE_LEN-1];

  // --------------------------------------------------------------------------
  // S1: pick H, S, V by mode; keep the byte ramps
  // --------------------------------------------------------------------------
  logic [HUE_W-1:0] s1_h_r;
  logic [FX_W-1:0]  s1_s_r, s1_v_r;
  logic [7:0]       s1_rx_r, s1_ry_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx_r <= quo_rx[7:0];
      s1_ry_r <= quo_ry[7:0];
      case (mode_r)
        MODE_FIX_H: begin
          s1_h_r <= HUE_W'({hue_fix_r, FRAC_BITS'(0)});
          s1_s_r <= quo_fx[FX_W-1:0];
          s1_v_r <= quo_fy[FX_W-1:0];
        end
        MODE_FIX_S: begin
          s1_h_r <= quo_hx;
          s1_s_r <= pct_fx_r;
          s1_v_r <= quo_fy[FX_W-1:0];
        end
        default: begin
          s1_h_r <= quo_hx;
          s1_s_r <= quo_fy[FX_W-1:0];
          s1_v_r <= pct_fx_r;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // S2: chroma C = V*S, hue/60 by reciprocal, sector and grey flag
  // --------------------------------------------------------------------------
  logic [2*FX_W-1:0]  vs_prod;
  logic [51:0]        h60_prod;
  sector_t            sec_nxt;
  logic [FX_W-1:0]    s2_c_r, s2_v_r;
  logic [H60_W-1:0]   s2_h60_r;
  sector_t            s2_sec_r;
  logic               s2_grey_r;
  logic [7:0]         s2_rx_r, s2_ry_r;

  assign vs_prod  = (2*FX_W)'(s1_v_r) * (2*FX_W)'(s1_s_r);
  assign h60_prod = 52'(s1_h_r) * 52'(RECIP_60);

  always_comb begin
    if (s1_h_r <= HUE_W'(60 << FRAC_BITS))       sec_nxt = SEC_RED_YEL;
    else if (s1_h_r <= HUE_W'(120 << FRAC_BITS)) sec_nxt = SEC_YEL_GRN;
    else if (s1_h_r <= HUE_W'(180 << FRAC_BITS)) sec_nxt = SEC_GRN_CYN;
    else if (s1_h_r <= HUE_W'(240 << FRAC_BITS)) sec_nxt = SEC_CYN_BLU;
    else if (s1_h_r <= HUE_W'(300 << FRAC_BITS)) sec_nxt = SEC_BLU_MAG;
    else                                         sec_nxt = SEC_MAG_RED;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_c_r    <= vs_prod[FRAC_BITS +: FX_W];
      s2_h60_r  <= h60_prod[32 +: H60_W];
      s2_sec_r  <= sec_nxt;
      s2_grey_r <= (s1_s_r == '0);
      s2_v_r    <= s1_v_r;
      s2_rx_r   <= s1_rx_r;
      s2_ry_r   <= s1_ry_r;
    end
  end

  // --------------------------------------------------------------------------
  // S3: X = C * (1 - |(h/60 mod 2) - 1|), m = V - C
  // --------------------------------------------------------------------------
  logic [FX_W-1:0]   t_mod, hue_dist, one_m_dist;
  logic [2*FX_W-1:0] x_prod;
  logic [FX_W-1:0]   s3_c_r, s3_x_r, s3_m_r, s3_v_r;
  sector_t           s3_sec_r;
  logic              s3_grey_r;
  logic [7:0]        s3_rx_r, s3_ry_r;

  assign t_mod      = s2_h60_r[FX_W-1:0];
  assign hue_dist   = (t_mod >= ONE_FX) ? (t_mod - ONE_FX) : (ONE_FX - t_mod);
  assign one_m_dist = ONE_FX - hue_dist;
  assign x_prod     = (2*FX_W)'(s2_c_r) * (2*FX_W)'(one_m_dist);

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_c_r    <= s2_c_r;
      s3_x_r    <= x_prod[FRAC_BITS +: FX_W];
      s3_m_r    <= s2_v_r - s2_c_r;
      s3_v_r    <= s2_v_r;
      s3_sec_r  <= s2_sec_r;
      s3_grey_r <= s2_grey_r;
      s3_rx_r   <= s2_rx_r;
      s3_ry_r   <= s2_ry_r;
    end
  end

  // --------------------------------------------------------------------------
  // S4: place C/X/0 by sector, add m, scale to bytes, final mode mux
  // --------------------------------------------------------------------------
  logic [FX_W-1:0] rf, gf, bf;
  logic [FX_W+7:0] rp, gp, bp;
  logic [7:0]      red_nxt, green_nxt, blue_nxt;
  logic [7:0]      red_r, green_r, blue_r;

  always_comb begin
    if (s3_grey_r) begin
      rf = s3_v_r;
      gf = s3_v_r;
      bf = s3_v_r;
    end else begin
      case (s3_sec_r)
        SEC_RED_YEL: begin rf = s3_c_r; gf = s3_x_r; bf = '0;     end
        SEC_YEL_GRN: begin rf = s3_x_r; gf = s3_c_r; bf = '0;     end
        SEC_GRN_CYN: begin rf = '0;     gf = s3_c_r; bf = s3_x_r; end
        SEC_CYN_BLU: begin rf = '0;     gf = s3_x_r; bf = s3_c_r; end
        SEC_BLU_MAG: begin rf = s3_x_r; gf = '0;     bf = s3_c_r; end
        default:     begin rf = s3_c_r; gf = '0;     bf = s3_x_r; end
      endcase
      rf = rf + s3_m_r;
      gf = gf + s3_m_r;
      bf = bf + s3_m_r;
    end
    // f * 255 as shift and subtract; f <= one, so the byte never overflows
    rp = ((FX_W+8)'(rf) << 8) - (FX_W+8)'(rf);
    gp = ((FX_W+8)'(gf) << 8) - (FX_W+8)'(gf);
    bp = ((FX_W+8)'(bf) << 8) - (FX_W+8)'(bf);

    case (mode_r)
      MODE_FIX_R: begin
        red_nxt = rgb_fix_r;   green_nxt = s3_rx_r;   blue_nxt = s3_ry_r;
      end
      MODE_FIX_G: begin
        red_nxt = s3_ry_r;     green_nxt = rgb_fix_r; blue_nxt = s3_rx_r;
      end
      MODE_FIX_B: begin
        red_nxt = s3_rx_r;     green_nxt = s3_ry_r;   blue_nxt = rgb_fix_r;
      end
      MODE_FIX_H, MODE_FIX_S, MODE_FIX_V: begin
        red_nxt   = rp[FRAC_BITS +: 8];
        green_nxt = gp[FRAC_BITS +: 8];
        blue_nxt  = bp[FRAC_BITS +: 8];
      end
      default: begin
        red_nxt = '0;          green_nxt = '0;        blue_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_red_value   = red_r;
  assign out_green_value = green_r;
  assign out_blue_value  = blue_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CCS_ASSERT_IMP(a_accept_enters, (in_valid && !in_stall), ##1 vld_r[0], "accepted transaction lost at pipe entry")
  `CCS_ASSERT_IMP(a_chroma_le_value, vld_r[QUO_W+1], s2_c_r <= s2_v_r, "chroma exceeds value")
  `CCS_ASSERT_IMP(a_x_le_chroma, vld_r[QUO_W+2], s3_x_r <= s3_c_r, "second component exceeds chroma")

endmodule
